@@ hdl/lpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefix deframer: beat layouts,
// result kinds, operation codes and register map.
// ----------------------------------------------------------------------------
package lpd_pkg;

  // header is a 4-byte big-endian length
  localparam int unsigned HdrBytes  = 4;
  localparam int unsigned CntW      = $clog2(HdrBytes);
  localparam int unsigned LenW      = 8 * HdrBytes;
  localparam int unsigned MaxLenW   = LenW - 1;
  // the last header byte completes the length
  localparam logic [CntW-1:0] HdrLastCnt = CntW'(HdrBytes - 1);

  // configuration port
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 3;
  localparam logic [MaxLenW-1:0] MaxLenReset = MaxLenW'(65536);

  // register indexes (byte address / 4)
  typedef enum logic {
    REG_MAX_PAYLOAD_LEN = 1'b0
  } reg_idx_e;

  // input operations
  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_CLOSE = 1'b1
  } op_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_BADLEN = 2'd1,
    KIND_ABORT  = 2'd2
  } kind_e;

  // one input beat
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } item_t;

  // one result beat
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

@@ hdl/length_prefix_deframer_core.sv @@
`timescale 1ns / 1ps
// an accepted beat passes the input register and then the result register
// of the deframing state machine; one beat per cycle while the result
// output is not stalled; beats without a result leave no bubble
// reset: asynchronous active-low; stream returns to the header phase and
// the maximum payload length to 65536
// ----------------------------------------------------------------------------
// length_prefix_deframer_core
// Splits a byte stream of 4-byte big-endian length-prefixed frames into
// payload bytes, bad-length errors and frame-abort notices.
// ----------------------------------------------------------------------------
module length_prefix_deframer_core import lpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  // input beats
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [7:0]          data_byte_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          result_kind_o,
  output logic [7:0]          payload_byte_o,
  output logic                last_of_frame_o
);

  logic [MaxLenW-1:0] max_len;
  logic               s1_valid_q, s1_valid_d;
  item_t              s1_item_q;
  logic               take;
  logic               in_accept;
  result_t            result;

  lpd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  // input register
  assign in_stall_o = s1_valid_q && !take;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (take) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= '{op: op_e'(operation_i), data: data_byte_i};
    end
  end

  lpd_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s1_valid_q),
    .item_i       (s1_item_q),
    .max_len_i    (max_len),
    .out_stall_i  (out_stall_i),
    .item_take_o  (take),
    .out_valid_o  (out_valid_o),
    .result_o     (result)
  );

  assign result_kind_o   = result.kind;
  assign payload_byte_o  = result.data;
  assign last_of_frame_o = result.last;

  // input stage only backs up behind a stalled, full result slot
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // end-of-frame marks only appear on payload bytes
  a_last_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_frame_o) |-> (result_kind_o == KIND_BYTE))
    else $error("last flag on a non-payload result");

  // error and abort results carry no byte
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (result_kind_o != KIND_BYTE)) |-> (payload_byte_o == 8'd0))
    else $error("status result carries a payload byte");

endmodule

@@ hdl/lpd_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_cfg
// APB-style register block holding the maximum accepted payload length.
// ----------------------------------------------------------------------------
module lpd_cfg import lpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output logic [MaxLenW-1:0]  max_len_o
);

  logic [MaxLenW-1:0] max_len_q, max_len_d;
  reg_idx_e           reg_idx;
  logic               hit;

  // register index from the word address
  assign reg_idx = reg_idx_e'(paddr[ApbAddrW-1]);
  assign hit     = (reg_idx == REG_MAX_PAYLOAD_LEN);
  assign pready  = 1'b1;

  // write on the access phase
  always_comb begin
    max_len_d = max_len_q;
    if (psel && penable && pwrite && hit) begin
      max_len_d = pwdata[MaxLenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = ApbDataW'(max_len_q);
    end
  end

  assign max_len_o = max_len_q;

endmodule

@@ hdl/lpd_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_step
// Deframing state machine: one registered beat in, header collection,
// length check and payload countdown, result register towards the output.
// ----------------------------------------------------------------------------
module lpd_step import lpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  item_t              item_i,
  input  logic [MaxLenW-1:0] max_len_i,
  input  logic               out_stall_i,
  output logic               item_take_o,
  output logic               out_valid_o,
  output result_t            result_o
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_CLOSED  = 3'b100
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [LenW-9:0]    shift_q, shift_d;
  logic [MaxLenW-1:0] remain_q, remain_d;
  logic               out_valid_q, out_valid_d;
  result_t            result_q, result_d;

  logic [LenW-1:0]    len;
  logic               has_result;
  logic               is_last;

  // take a beat when the result slot is free or drains this cycle
  assign item_take_o = item_valid_i && (!out_valid_q || !out_stall_i);

  assign len     = {shift_q, item_i.data};
  assign is_last = (remain_q <= MaxLenW'(1));

  // next state and result for the beat held at the input
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    remain_d   = remain_q;
    has_result = 1'b0;
    result_d   = '{kind: KIND_BYTE, data: 8'd0, last: 1'b0};

    unique case (item_i.op)
      OP_CLOSE: begin
        // clear the stream, report a partial frame
        if (phase_q == PH_PAYLOAD) begin
          has_result    = 1'b1;
          result_d.kind = KIND_ABORT;
        end
        phase_d  = PH_HEADER;
        cnt_d    = '0;
        shift_d  = '0;
        remain_d = '0;
      end
      OP_DATA: begin
        unique case (phase_q)
          PH_HEADER: begin
            cnt_d   = cnt_q + CntW'(1);
            shift_d = len[LenW-9:0];
            if (cnt_q == HdrLastCnt) begin
              shift_d = '0;
              if (len[LenW-1] || (len > {1'b0, max_len_i})) begin
                // negative or oversized length closes the stream
                phase_d       = PH_CLOSED;
                remain_d      = '0;
                has_result    = 1'b1;
                result_d.kind = KIND_BADLEN;
              end else if (len != '0) begin
                phase_d  = PH_PAYLOAD;
                remain_d = len[MaxLenW-1:0];
              end
            end
          end
          PH_PAYLOAD: begin
            has_result    = 1'b1;
            result_d.data = item_i.data;
            result_d.last = is_last;
            if (is_last) begin
              phase_d  = PH_HEADER;
              cnt_d    = '0;
              shift_d  = '0;
              remain_d = '0;
            end else begin
              remain_d = remain_q - MaxLenW'(1);
            end
          end
          default: begin
            // closed or a stray code: drop the byte
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // result slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (item_take_o) begin
      out_valid_d = has_result;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      cnt_q       <= '0;
      shift_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (item_take_o) begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        shift_q  <= shift_d;
        remain_q <= remain_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (item_take_o && has_result) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-prefix deframer. A queue of beats feeds
// a clocked driver. A clocked monitor runs each accepted beat through a
// predictor of the deframing state machine and compares every result beat
// against the oldest prediction. The maximum payload length is changed
// between phases over the APB port and read back.
// ----------------------------------------------------------------------------
module testbench;
  import lpd_pkg::*;

  localparam int unsigned WatchdogLimit  = 3000;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned PhaseBeats     = 90;
  localparam int unsigned UnmappedIdx    = int'(REG_MAX_PAYLOAD_LEN) + 1;
  localparam logic [ApbAddrW-1:0] MaxLenAddr   = ApbAddrW'(4 * int'(REG_MAX_PAYLOAD_LEN));
  localparam logic [ApbAddrW-1:0] UnmappedAddr = ApbAddrW'(4 * UnmappedIdx);
  localparam logic [ApbDataW-1:0] MaxLenSettings [6] =
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'd4, 32'd1, 32'd200, 32'd65536};

  // stream phases of the predictor
  typedef enum logic [1:0] {
    ST_HEADER  = 2'd0,
    ST_PAYLOAD = 2'd1,
    ST_CLOSED  = 2'd2
  } stream_phase_e;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [ApbAddrW-1:0] paddr           = '0;
  logic [ApbDataW-1:0] pwdata          = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic                operation_i     = 1'b0;
  logic [7:0]          data_byte_i     = 8'h00;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic [1:0]          result_kind_o;
  logic [7:0]          payload_byte_o;
  logic                last_of_frame_o;

  // beats waiting to be sent and results still owed by the block
  item_t   pending_beats[$];
  result_t expected_results[$];
  int unsigned queued_beats = 0;
  int unsigned fail_count   = 0;

  // handshake flags, set at the rising edge and read at the falling edge
  bit in_beat_taken  = 1'b0;
  bit out_beat_taken = 1'b0;

  // predictor state
  stream_phase_e stream_phase = ST_HEADER;
  logic [1:0]    hdr_count    = 2'd0;
  logic [31:0]   len_accum    = '0;
  logic [30:0]   payload_left = '0;
  logic [30:0]   max_len_cfg  = 31'd65536;

  // long receiver hold-off requests
  int unsigned hold_requests = 0;

  length_prefix_deframer_core dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .data_byte_i,
    .out_valid_o,
    .out_stall_i,
    .result_kind_o,
    .payload_byte_o,
    .last_of_frame_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor: one accepted beat in, zero or one expected result out
  function automatic void deframe_beat(op_e op, logic [7:0] data);
    logic [31:0] len;
    if (op == OP_CLOSE) begin
      if (stream_phase == ST_PAYLOAD) begin
        expected_results.push_back('{kind: KIND_ABORT, data: 8'h00, last: 1'b0});
      end
      stream_phase = ST_HEADER;
      hdr_count    = 2'd0;
      len_accum    = '0;
      payload_left = '0;
      return;
    end
    case (stream_phase)
      ST_HEADER: begin
        len       = {len_accum[23:0], data};
        hdr_count = hdr_count + 2'd1;
        if (hdr_count != 2'd0) begin
          len_accum = len;
        end else begin
          len_accum = '0;
          if (len[31] || len[30:0] > max_len_cfg) begin
            stream_phase = ST_CLOSED;
            payload_left = '0;
            expected_results.push_back('{kind: KIND_BADLEN, data: 8'h00, last: 1'b0});
          end else if (len != '0) begin
            stream_phase = ST_PAYLOAD;
            payload_left = len[30:0];
          end
        end
      end
      ST_PAYLOAD: begin
        if (payload_left <= 31'd1) begin
          expected_results.push_back('{kind: KIND_BYTE, data: data, last: 1'b1});
          stream_phase = ST_HEADER;
          hdr_count    = 2'd0;
          len_accum    = '0;
          payload_left = '0;
        end else begin
          expected_results.push_back('{kind: KIND_BYTE, data: data, last: 1'b0});
          payload_left = payload_left - 31'd1;
        end
      end
      default: begin
        // closed: data ignored until a close beat
      end
    endcase
  endfunction

  // input driver: one beat at a time from the pending queue
  always @(negedge clk_i) begin : drive_beats
    logic offer;
    item_t beat;
    static int unsigned send_gap = 0;
    static bit send_burst = 1'b0;
    offer = in_valid_i && !in_beat_taken;
    if (!offer && rst_ni) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_beats.size() > 0) begin
        beat = pending_beats.pop_front();
        operation_i <= beat.op;
        data_byte_i <= beat.data;
        offer = 1'b1;
        if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 18);
      end
    end
    in_valid_i <= offer;
  end

  // result receiver: random stall per beat, plus one long hold-off on request
  always @(negedge clk_i) begin : drive_stall
    logic stall;
    static int unsigned out_wait = 0;
    static int unsigned long_hold = 0;
    static int unsigned holds_served = 0;
    static bit recv_burst = 1'b0;
    if (hold_requests != holds_served) begin
      holds_served++;
      long_hold = LongHoldCycles;
    end
    if (out_beat_taken) begin
      if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
      out_wait = recv_burst ? 0 : $urandom_range(0, 18);
    end
    if (long_hold > 0) begin
      long_hold--;
      stall = 1'b1;
    end else if (out_wait > 0) begin
      out_wait--;
      stall = 1'b1;
    end else begin
      stall = 1'b0;
    end
    out_stall_i <= stall;
  end

  // monitor: predict on input beats, check output beats, watchdog
  always @(posedge clk_i) begin : watch_beats
    result_t want;
    static int unsigned idle_cycles = 0;
    in_beat_taken  = rst_ni && in_valid_i && !in_stall_o;
    out_beat_taken = rst_ni && out_valid_o && !out_stall_i;
    if (in_beat_taken) deframe_beat(op_e'(operation_i), data_byte_i);
    if (out_beat_taken) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: kind %0d byte %02h last %0b",
               result_kind_o, payload_byte_o, last_of_frame_o);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_kind_o !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, result_kind_o);
          fail_count++;
        end
        if (payload_byte_o !== want.data) begin
          $error("payload_byte: expected %02h, got %02h", want.data, payload_byte_o);
          fail_count++;
        end
        if (last_of_frame_o !== want.last) begin
          $error("last_of_frame: expected %0b, got %0b", want.last, last_of_frame_o);
          fail_count++;
        end
      end
    end
    if (in_beat_taken || out_beat_taken) idle_cycles = 0;
    else if (rst_ni) idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic apb_write(input logic [ApbAddrW-1:0] addr,
                           input logic [ApbDataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [ApbAddrW-1:0] addr,
                          output logic [ApbDataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    value = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // read back the length limit and compare with the predictor's copy
  task automatic check_max_len();
    logic [ApbDataW-1:0] got;
    apb_read(MaxLenAddr, got);
    if (got !== {1'b0, max_len_cfg}) begin
      $error("max_payload_len: expected %0d, got %0d", {1'b0, max_len_cfg}, got);
      fail_count++;
    end
  endtask

  function automatic void push_beat(op_e op, logic [7:0] data);
    pending_beats.push_back('{op: op, data: data});
    queued_beats++;
  endfunction

  function automatic void push_header(logic [31:0] len);
    for (int i = 0; i < 4; i++) push_beat(OP_DATA, len[31 - 8 * i -: 8]);
  endfunction

  // mostly small lengths, with the limit, just past it and negative ones
  function automatic logic [31:0] pick_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 32'($urandom_range(1, 6));
    if (pick < 60) return 32'd0;
    if (pick < 70) return {1'b0, max_len_cfg};
    if (pick < 78) return {1'b0, max_len_cfg} + 32'd1;
    if (pick < 88) return {1'b1, 31'($urandom)};
    return 32'($urandom);
  endfunction

  // one sequence from the header phase back to the header phase
  function automatic void queue_random_sequence();
    int unsigned pick;
    int unsigned cut;
    int unsigned n;
    logic [31:0] len;
    pick = $urandom_range(0, 99);
    // noise, then a close to realign
    if (pick < 8) begin
      n = $urandom_range(1, 5);
      repeat (n) push_beat(op_e'($urandom_range(0, 1)), 8'($urandom));
      push_beat(OP_CLOSE, 8'($urandom));
      return;
    end
    len = pick_length();
    // header cut short by a close
    if (pick < 18) begin
      cut = $urandom_range(0, 3);
      for (int i = 0; i < cut; i++) push_beat(OP_DATA, len[31 - 8 * i -: 8]);
      push_beat(OP_CLOSE, 8'($urandom));
      return;
    end
    push_header(len);
    if (len[31] || len[30:0] > max_len_cfg) begin
      // closed: stray bytes, then one or two closes
      n = $urandom_range(0, 3);
      repeat (n) push_beat(OP_DATA, 8'($urandom));
      n = $urandom_range(1, 2);
      repeat (n) push_beat(OP_CLOSE, 8'($urandom));
    end else if (len != '0) begin
      if (len <= 32'd256 && $urandom_range(0, 9) != 0) begin
        repeat (len) push_beat(OP_DATA, 8'($urandom));
      end else begin
        n = (len > 32'd8) ? $urandom_range(0, 8) : $urandom_range(0, len - 1);
        repeat (n) push_beat(OP_DATA, 8'($urandom));
        push_beat(OP_CLOSE, 8'($urandom));
      end
    end
  endfunction

  // block idle: nothing queued, nothing offered, nothing owed
  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : run_stimulus
    int unsigned target;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    check_max_len();

    // directed: single-byte frame, zero length, abort, negative length,
    // data while closed, close when closed, close mid-header
    push_header(32'h0000_0001);
    push_beat(OP_DATA, 8'hFF);
    push_header(32'h0000_0000);
    push_header(32'h0000_0003);
    push_beat(OP_DATA, 8'h00);
    push_beat(OP_DATA, 8'hA5);
    push_beat(OP_CLOSE, 8'h00);
    push_header(32'h8001_0000);
    push_beat(OP_DATA, 8'hFF);
    push_beat(OP_CLOSE, 8'hFF);
    push_beat(OP_DATA, 8'h7F);
    push_beat(OP_CLOSE, 8'h5A);
    wait_drained();

    target = queued_beats;
    for (int p = 0; p < 6; p++) begin
      if (p == 3) begin
        apb_write(UnmappedAddr, 32'($urandom));
        check_max_len();
      end
      apb_write(MaxLenAddr, MaxLenSettings[p]);
      max_len_cfg = MaxLenSettings[p][30:0];
      check_max_len();
      if (p == 4) hold_requests++;
      target += PhaseBeats;
      while (queued_beats < target) queue_random_sequence();
      wait_drained();
    end

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
